FILE: src/csvfd_pkg.sv
// ----------------------------------------------------------------------------
// CSV field deframer package
// Shared types and constants for the byte classifier, the entry queue and the
// result sequencer.
// ----------------------------------------------------------------------------
package csvfd_pkg;

   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      MODE_ROW_START  = 3'd0,
      MODE_CELL_START = 3'd1,
      MODE_UNQUOTED   = 3'd2,
      MODE_QUOTED     = 3'd3,
      MODE_QUOTE_SEEN = 3'd4
   } mode_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic       row_end;
      logic       quoted;
      logic       last;
   } result_type;

   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

FILE: src/csvfd_front.sv
// ----------------------------------------------------------------------------
// CSV field deframer byte classifier
// Tracks the parse mode, classifies each accepted byte and pushes the one or
// two result words it causes into the queue as a single entry.
// ----------------------------------------------------------------------------
module csvfd_front
   import csvfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       queue_full,
   output logic       push,
   output entry_type  push_entry
);

   mode_type mode_ff, mode_in;
   logic     quoted_ff, quoted_in;

   logic       accept;
   logic       is_comma, is_quote, is_newline;
   logic       do_unquoted;
   logic       a_valid, b_valid;
   result_type a_res, b_res;
   mode_type   mode_next;
   logic       quoted_next;

   assign req_ready  = !queue_full;
   assign accept     = req_valid && req_ready;
   assign is_comma   = (req_in_byte == CH_COMMA);
   assign is_quote   = (req_in_byte == CH_QUOTE);
   assign is_newline = (req_in_byte == CH_CR) || (req_in_byte == CH_LF);

   always_comb begin
      mode_next   = mode_ff;
      quoted_next = quoted_ff;
      do_unquoted = 1'b0;
      a_valid     = 1'b0;
      a_res       = '0;
      b_valid     = 1'b0;
      b_res       = '0;

      case (mode_ff)
         MODE_CELL_START: begin
            if (is_quote) begin
               quoted_next = 1'b1;
               mode_next   = MODE_QUOTED;
            end else begin
               do_unquoted = 1'b1;
            end
         end
         MODE_UNQUOTED: begin
            do_unquoted = 1'b1;
         end
         MODE_QUOTED: begin
            if (is_quote) begin
               mode_next = MODE_QUOTE_SEEN;
            end else begin
               a_valid      = 1'b1;
               a_res.kind   = KIND_DATA;
               a_res.data   = req_in_byte;
            end
         end
         MODE_QUOTE_SEEN: begin
            if (is_quote) begin
               a_valid    = 1'b1;
               a_res.kind = KIND_DATA;
               a_res.data = CH_QUOTE;
               mode_next  = MODE_QUOTED;
            end else begin
               do_unquoted = 1'b1;
            end
         end
         default: begin
            mode_next = MODE_ROW_START;
            if (!is_newline) begin
               if (is_quote) begin
                  quoted_next = 1'b1;
                  mode_next   = MODE_QUOTED;
               end else begin
                  do_unquoted = 1'b1;
               end
            end
         end
      endcase

      if (do_unquoted) begin
         a_valid = 1'b1;
         if (is_comma) begin
            a_res.kind    = KIND_END;
            a_res.row_end = 1'b0;
            a_res.quoted  = quoted_ff;
            quoted_next   = 1'b0;
            mode_next     = MODE_CELL_START;
         end else if (is_newline) begin
            a_res.kind    = KIND_END;
            a_res.row_end = 1'b1;
            a_res.quoted  = quoted_ff;
            quoted_next   = 1'b0;
            mode_next     = MODE_ROW_START;
         end else begin
            a_res.kind = KIND_DATA;
            a_res.data = req_in_byte;
            mode_next  = MODE_UNQUOTED;
         end
      end

      if (req_end_of_input) begin
         if (mode_next != MODE_ROW_START) begin
            b_valid       = 1'b1;
            b_res.kind    = KIND_END;
            b_res.row_end = 1'b1;
            b_res.quoted  = quoted_next;
         end
         mode_next   = MODE_ROW_START;
         quoted_next = 1'b0;
      end

      a_res.last = !b_valid;
      b_res.last = 1'b1;

      push_entry = '0;
      if (a_valid) begin
         push_entry.first  = a_res;
         push_entry.second = b_res;
         push_entry.two    = b_valid;
      end else begin
         push_entry.first = b_res;
      end
      push = accept && (a_valid || b_valid);

      mode_in   = accept ? mode_next : mode_ff;
      quoted_in = accept ? quoted_next : quoted_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_ROW_START;
         quoted_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         quoted_ff <= quoted_in;
      end
   end

endmodule

FILE: src/csvfd_queue.sv
// ----------------------------------------------------------------------------
// CSV field deframer entry queue
// Short first-in first-out queue that decouples the classifier from the
// result sequencer.
// ----------------------------------------------------------------------------
module csvfd_queue
   import csvfd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output head_type  head
);

   entry_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && head.valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: src/csvfd_back.sv
// ----------------------------------------------------------------------------
// CSV field deframer result sequencer
// Takes entries from the queue and delivers their result words one at a time
// through a registered output stage.
// ----------------------------------------------------------------------------
module csvfd_back
   import csvfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  head_type   head,
   output logic       pop,
   output logic       rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_row_end,
   output logic       rsp_cell_quoted,
   output logic       rsp_last_of_run,
   output logic       rsp_valid,
   input  logic       rsp_ready
);

   result_type rsp_res_ff, rsp_res_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type pend_res_ff, pend_res_in;
   logic       pend_ff, pend_in;
   logic       load;

   assign load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      pop          = 1'b0;
      rsp_res_in   = rsp_res_ff;
      rsp_valid_in = rsp_valid_ff;
      pend_res_in  = pend_res_ff;
      pend_in      = pend_ff;
      if (load) begin
         if (pend_ff) begin
            rsp_res_in   = pend_res_ff;
            rsp_valid_in = 1'b1;
            pend_in      = 1'b0;
         end else if (head.valid) begin
            pop          = 1'b1;
            rsp_res_in   = head.entry.first;
            rsp_valid_in = 1'b1;
            pend_in      = head.entry.two;
            pend_res_in  = head.entry.second;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff  <= rsp_res_in;
      pend_res_ff <= pend_res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_res_ff.kind;
   assign rsp_out_byte    = rsp_res_ff.data;
   assign rsp_row_end     = rsp_res_ff.row_end;
   assign rsp_cell_quoted = rsp_res_ff.quoted;
   assign rsp_last_of_run = rsp_res_ff.last;

endmodule

FILE: src/csv_field_deframer.sv
// ----------------------------------------------------------------------------
// CSV field deframer
// Splits a CSV byte stream into cell content bytes and end-of-cell markers.
// ----------------------------------------------------------------------------
// The req channel takes one byte of CSV text per word, with req_end_of_input
// set on the final byte of a text. The rsp channel delivers one result word
// per cycle: a content byte (rsp_kind 0) or an end-of-cell marker (rsp_kind 1)
// that carries the row end and quoted flags. rsp_last_of_run marks the last
// word caused by one input byte. A byte causes zero, one or two words.
// A byte is accepted in every cycle while the four-entry queue has room.
// The first word caused by a byte is written into a queue slot and then into
// the output register before it appears on rsp.
// The output register delivers one word per cycle while rsp_ready is high,
// so a byte that causes two words holds the output for both words in turn,
// and sustained throughput is one byte per cycle when no byte causes two words.
// When rsp_ready is held low, the queue fills and req_ready falls once it
// holds four entries; no word is lost or repeated.
// Reset returns the parser to row start, empties the queue and clears
// rsp_valid in the next cycle.
// ----------------------------------------------------------------------------
module csv_field_deframer
   import csvfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_row_end,
   output logic       rsp_cell_quoted,
   output logic       rsp_last_of_run,
   output logic       rsp_valid,
   input  logic       rsp_ready
);

   logic      queue_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   head_type  head;

   csvfd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   csvfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head)
   );

   csvfd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_row_end     (rsp_row_end),
      .rsp_cell_quoted (rsp_cell_quoted),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready)
   );

`ifndef SYNTHESIS
   a_data_flags_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_DATA)) |-> (!rsp_row_end && !rsp_cell_quoted))
      else $error("Content word carries cell end flags.");

   a_end_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_END)) |-> (rsp_out_byte == 8'h00))
      else $error("End of cell word carries a nonzero byte.");

   a_reset_clears_valid: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("Result valid after reset.");
`endif

endmodule

FILE: tb/sv/tb_csv_field_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field deframer testbench
// Feeds CSV texts byte by byte into the deframer and checks every content
// word and cell end against a parser kept in step inside the bench. A short
// directed text set is followed by random texts, mostly well formed with
// random content and some raw noise. Idle gaps on both sides, one long
// receiver hold-off and a final gap-free stretch exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_csv_field_deframer;
   import csvfd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [7:0] ch;
      logic       last_byte;
   } text_item_type;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic [7:0] req_in_byte      = 8'h00;
   logic       req_end_of_input = 1'b0;
   logic       req_valid        = 1'b0;
   logic       req_ready;
   logic       rsp_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_row_end;
   logic       rsp_cell_quoted;
   logic       rsp_last_of_run;
   logic       rsp_valid;
   logic       rsp_ready        = 1'b0;

   text_item_type pending_bytes[$];
   result_type    due_words[$];
   text_item_type next_item;
   result_type    want;

   mode_type   parse_state      = MODE_ROW_START;
   logic       open_cell_quoted = 1'b0;

   logic       idle_on          = 1'b0;
   logic       hold_wanted      = 1'b0;
   logic       hold_started     = 1'b0;
   int         send_gap_left    = 0;
   int         stall_left       = 0;
   int         queued_bytes     = 0;
   int         error_count      = 0;
   int         cycle_count      = 0;
   int         texts_done       = 0;
   int         content_words    = 0;
   int         cell_ends        = 0;
   int         input_stalls     = 0;

   csv_field_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .rsp_kind         (rsp_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_row_end      (rsp_row_end),
      .rsp_cell_quoted  (rsp_cell_quoted),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready)
   );

   always #2 clock = ~clock;

   // Parser kept in step with the block.
   task automatic put_word(input logic kind, input logic [7:0] data, input logic row_end,
                           input logic quoted);
      result_type w;
      w.kind    = kind;
      w.data    = data;
      w.row_end = row_end;
      w.quoted  = quoted;
      w.last    = 1'b0;
      due_words.insert(due_words.size(), w);
   endtask

   task automatic close_cell(input logic row_end);
      put_word(KIND_END, 8'h00, row_end, open_cell_quoted);
      open_cell_quoted = 1'b0;
   endtask

   task automatic take_unquoted(input logic [7:0] c);
      if (c == CH_COMMA) begin
         close_cell(1'b0);
         parse_state = MODE_CELL_START;
      end else if (c == CH_CR || c == CH_LF) begin
         close_cell(1'b1);
         parse_state = MODE_ROW_START;
      end else begin
         put_word(KIND_DATA, c, 1'b0, 1'b0);
         parse_state = MODE_UNQUOTED;
      end
   endtask

   task automatic take_cell_start(input logic [7:0] c);
      if (c == CH_QUOTE) begin
         open_cell_quoted = 1'b1;
         parse_state = MODE_QUOTED;
      end else begin
         take_unquoted(c);
      end
   endtask

   task automatic deframe_byte(input logic [7:0] c, input logic text_end);
      int         count_before;
      result_type w;
      count_before = due_words.size();
      case (parse_state)
         MODE_CELL_START: take_cell_start(c);
         MODE_UNQUOTED:   take_unquoted(c);
         MODE_QUOTED: begin
            if (c == CH_QUOTE) parse_state = MODE_QUOTE_SEEN;
            else put_word(KIND_DATA, c, 1'b0, 1'b0);
         end
         MODE_QUOTE_SEEN: begin
            if (c == CH_QUOTE) begin
               put_word(KIND_DATA, CH_QUOTE, 1'b0, 1'b0);
               parse_state = MODE_QUOTED;
            end else begin
               take_unquoted(c);
            end
         end
         default: begin
            parse_state = MODE_ROW_START;
            if (c != CH_CR && c != CH_LF) take_cell_start(c);
         end
      endcase
      if (text_end) begin
         if (parse_state != MODE_ROW_START) close_cell(1'b1);
         parse_state = MODE_ROW_START;
         open_cell_quoted = 1'b0;
      end
      if (due_words.size() > count_before) begin
         w = due_words.pop_back();
         w.last = 1'b1;
         due_words.insert(due_words.size(), w);
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] exp_val,
                              input logic [7:0] got);
      if (got !== exp_val) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, got);
         error_count++;
      end
   endtask

   // Stimulus helpers.
   task automatic queue_byte(input logic [7:0] c, input logic text_end);
      text_item_type item;
      item.ch        = c;
      item.last_byte = text_end;
      pending_bytes.insert(pending_bytes.size(), item);
      queued_bytes++;
   endtask

   function automatic logic [7:0] pick_byte(input int special_pct);
      if ($urandom_range(0, 99) < special_pct) begin
         case ($urandom_range(0, 3))
            0:       return CH_COMMA;
            1:       return CH_QUOTE;
            2:       return CH_CR;
            default: return CH_LF;
         endcase
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (c == CH_COMMA || c == CH_QUOTE || c == CH_CR || c == CH_LF)
         c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   task automatic queue_random_text();
      logic [7:0] text[$];
      logic [7:0] c;
      int         rows;
      int         cells;
      int         len;
      int         style;
      if ($urandom_range(0, 5) == 0) begin
         len = $urandom_range(1, 24);
         for (int i = 0; i < len; i++) text.insert(text.size(), pick_byte(35));
      end else begin
         rows = $urandom_range(1, 4);
         for (int r = 0; r < rows; r++) begin
            if ($urandom_range(0, 7) == 0)
               text.insert(text.size(), $urandom_range(0, 1) ? CH_LF : CH_CR);
            cells = $urandom_range(1, 4);
            for (int k = 0; k < cells; k++) begin
               if (k > 0) text.insert(text.size(), CH_COMMA);
               style = $urandom_range(0, 9);
               len = $urandom_range(0, 6);
               if (style < 4) begin
                  for (int i = 0; i < len; i++)
                     text.insert(text.size(),
                                 (i > 0 && $urandom_range(0, 15) == 0) ? CH_QUOTE
                                                                       : plain_byte());
               end else if (style < 9) begin
                  text.insert(text.size(), CH_QUOTE);
                  for (int i = 0; i < len; i++) begin
                     c = pick_byte(30);
                     text.insert(text.size(), c);
                     if (c == CH_QUOTE) text.insert(text.size(), CH_QUOTE);
                  end
                  text.insert(text.size(), CH_QUOTE);
                  if (style == 8)
                     for (int i = $urandom_range(1, 3); i > 0; i--)
                        text.insert(text.size(), plain_byte());
               end else begin
                  for (int i = 0; i < len; i++) text.insert(text.size(), pick_byte(35));
               end
            end
            if (r == rows - 1 && $urandom_range(0, 9) == 0) begin
               text.insert(text.size(), CH_COMMA);
            end else if (r < rows - 1 || $urandom_range(0, 1) == 0) begin
               case ($urandom_range(0, 2))
                  0:       text.insert(text.size(), CH_CR);
                  1:       text.insert(text.size(), CH_LF);
                  default: begin
                     text.insert(text.size(), CH_CR);
                     text.insert(text.size(), CH_LF);
                  end
               endcase
            end
         end
      end
      if (text.size() == 0) text.insert(text.size(), plain_byte());
      for (int i = 0; i < text.size(); i++) queue_byte(text[i], i == text.size() - 1);
   endtask

   task automatic drain_pending();
      while (pending_bytes.size() != 0) @(negedge clock);
   endtask

   // Sender.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap_left = 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap_left > 0) begin
            req_valid <= 1'b0;
            send_gap_left = send_gap_left - 1;
         end else if (pending_bytes.size() > 0) begin
            next_item = pending_bytes.pop_front();
            req_in_byte <= next_item.ch;
            req_end_of_input <= next_item.last_byte;
            req_valid <= 1'b1;
            if (idle_on && $urandom_range(0, 9) == 0) send_gap_left = $urandom_range(1, 14);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (hold_wanted && !hold_started) begin
         hold_started = 1'b1;
         stall_left = 80;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 14);
      end
   end

   // Monitor: predict from accepted bytes, then check accepted words.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_ready) input_stalls++;
         if (req_valid && req_ready) begin
            deframe_byte(req_in_byte, req_end_of_input);
            if (req_end_of_input) texts_done++;
         end
         if (rsp_valid && rsp_ready) begin
            if (rsp_kind === KIND_END) cell_ends++;
            else content_words++;
            if (due_words.size() == 0) begin
               $display("%0t: expected no word, actual kind %0b byte %0h row_end %0b quoted %0b",
                        $time, rsp_kind, rsp_out_byte, rsp_row_end, rsp_cell_quoted);
               error_count++;
            end else begin
               want = due_words.pop_front();
               check_field("kind", 8'(want.kind), 8'(rsp_kind));
               check_field("out_byte", want.data, rsp_out_byte);
               check_field("row_end", 8'(want.row_end), 8'(rsp_row_end));
               check_field("cell_quoted", 8'(want.quoted), 8'(rsp_cell_quoted));
               check_field("last_of_run", 8'(want.last), 8'(rsp_last_of_run));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out, %0d words still due", $time, due_words.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idle_on = 1'b1;

      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(CH_QUOTE, 1'b0);
      queue_byte(CH_COMMA, 1'b0);
      queue_byte(CH_QUOTE, 1'b0);
      queue_byte(CH_COMMA, 1'b0);
      queue_byte(CH_CR, 1'b0);
      queue_byte(CH_QUOTE, 1'b0);
      queue_byte(CH_QUOTE, 1'b0);
      queue_byte(CH_QUOTE, 1'b0);
      queue_byte("x", 1'b0);
      queue_byte(CH_CR, 1'b0);
      queue_byte(CH_LF, 1'b0);
      queue_byte(CH_COMMA, 1'b0);
      queue_byte(CH_COMMA, 1'b1);
      queue_byte(CH_QUOTE, 1'b0);
      queue_byte("y", 1'b1);
      queue_byte(CH_QUOTE, 1'b0);
      queue_byte(CH_QUOTE, 1'b0);
      queue_byte(CH_LF, 1'b0);
      queue_byte(CH_CR, 1'b1);
      queue_byte(8'h55, 1'b0);
      queue_byte(8'hAA, 1'b1);
      queue_byte(CH_QUOTE, 1'b0);
      queue_byte(CH_QUOTE, 1'b1);

      while (queued_bytes < 650) queue_random_text();
      drain_pending();
      while (pending_bytes.size() < 40) queue_random_text();
      hold_wanted = 1'b1;
      while (queued_bytes < 1150) queue_random_text();
      drain_pending();
      idle_on = 1'b0;
      while (queued_bytes < 1350) queue_random_text();
      drain_pending();

      while (req_valid || due_words.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (due_words.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, due_words.size());
         error_count++;
      end

      $display("Sent %0d bytes in %0d texts; checked %0d content words and %0d cell ends.",
               queued_bytes, texts_done, content_words, cell_ends);
      $display("Input was held back on %0d cycles; %0d mismatches.", input_stalls, error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/csvfd_pkg.sv
src/csvfd_front.sv
src/csvfd_queue.sv
src/csvfd_back.sv
src/csv_field_deframer.sv
tb/sv/tb_csv_field_deframer.sv
